### rtl/core/jse_pkg.sv
// jse_pkg: shared types, constants and microcode rom for the julia set escape test
// used by jse_datapath and julia_set_escape_test; no dependencies
`default_nettype none

package jse_pkg;

  localparam int DEFAULT_FRAC_BITS  = 28;
  localparam int DEFAULT_WORD_WIDTH = 32;

  localparam int IN_W    = 31;
  localparam int CNT_W   = 10;
  localparam int INDEX_W = 2;

  localparam logic signed [IN_W-1:0] C_REAL_RESET = 31'sd26843546;
  localparam logic signed [IN_W-1:0] C_IMAG_RESET = 31'sd222801428;
  localparam logic [CNT_W-1:0]       LIMIT_RESET  = 10'd200;

  typedef enum logic [INDEX_W-1:0] {
    REG_C_REAL = 2'd0,
    REG_C_IMAG = 2'd1,
    REG_LIMIT  = 2'd2
  } jse_reg_t;

  typedef enum logic [1:0] {
    STEP_IDLE = 2'd0,
    STEP_MUL  = 2'd1,
    STEP_EVAL = 2'd2
  } jse_step_t;

  typedef struct packed {
    logic      wait_start;
    logic      load_z;
    logic      mul_en;
    logic      chk_mag;
    logic      chk_sum;
    logic      chk_last;
    logic      upd_z;
    jse_step_t next;
  } jse_uword_t;

  typedef struct packed {
    logic load_z;
    logic mul_en;
    logic upd_z;
  } jse_ctrl_t;

  typedef struct packed {
    logic mag_esc;
    logic sum_esc;
  } jse_flags_t;

  function automatic jse_uword_t jse_ucode(input jse_step_t step);
    jse_uword_t w;
    w = '{wait_start: 1'b1, load_z: 1'b1, mul_en: 1'b0, chk_mag: 1'b0, chk_sum: 1'b0,
          chk_last: 1'b0, upd_z: 1'b0, next: STEP_MUL};
    unique case (step)
      STEP_IDLE: begin
        w = '{wait_start: 1'b1, load_z: 1'b1, mul_en: 1'b0, chk_mag: 1'b0, chk_sum: 1'b0,
              chk_last: 1'b0, upd_z: 1'b0, next: STEP_MUL};
      end
      STEP_MUL: begin
        w = '{wait_start: 1'b0, load_z: 1'b0, mul_en: 1'b1, chk_mag: 1'b1, chk_sum: 1'b0,
              chk_last: 1'b0, upd_z: 1'b0, next: STEP_EVAL};
      end
      STEP_EVAL: begin
        w = '{wait_start: 1'b0, load_z: 1'b0, mul_en: 1'b0, chk_mag: 1'b0, chk_sum: 1'b1,
              chk_last: 1'b1, upd_z: 1'b1, next: STEP_MUL};
      end
      default: begin
        w = '{wait_start: 1'b0, load_z: 1'b0, mul_en: 1'b0, chk_mag: 1'b0, chk_sum: 1'b0,
              chk_last: 1'b0, upd_z: 1'b0, next: STEP_IDLE};
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/core/jse_datapath.sv
// jse_datapath: z registers, squaring multipliers and escape tests for one round
// depends on jse_pkg
`default_nettype none

module jse_datapath #(
  parameter int FRAC_BITS  = jse_pkg::DEFAULT_FRAC_BITS,
  parameter int WORD_WIDTH = jse_pkg::DEFAULT_WORD_WIDTH
) (
  input  wire logic                              clk,
  input  wire jse_pkg::jse_ctrl_t                ctrl,
  input  wire logic signed [jse_pkg::IN_W-1:0]   start_real,
  input  wire logic signed [jse_pkg::IN_W-1:0]   start_imag,
  input  wire logic signed [jse_pkg::IN_W-1:0]   c_real,
  input  wire logic signed [jse_pkg::IN_W-1:0]   c_imag,
  output jse_pkg::jse_flags_t                    flags
);

  localparam int MW  = (WORD_WIDTH < FRAC_BITS + 1) ? WORD_WIDTH : FRAC_BITS + 1;
  localparam int PW  = 2 * MW;
  localparam int EW  = (PW + 1 > FRAC_BITS + 3) ? PW + 1 : FRAC_BITS + 3;
  localparam int SW0 = (EW > WORD_WIDTH) ? EW : WORD_WIDTH;
  localparam int SW  = ((SW0 > 32) ? SW0 : 32) + 3;

  localparam logic [SW-1:0] TWO_FIX  = SW'(1) << (FRAC_BITS + 1);
  localparam logic [SW-1:0] FOUR_FIX = SW'(4) << FRAC_BITS;
  localparam logic [SW-1:0] FRAC_MSK = (SW'(1) << FRAC_BITS) - SW'(1);
  localparam logic signed [SW-1:0] WMAX = $signed((SW'(1) << (WORD_WIDTH - 1)) - SW'(1));
  localparam logic signed [SW-1:0] WMIN = -WMAX - SW'(1);

  logic signed [WORD_WIDTH-1:0] z_real;
  logic signed [WORD_WIDTH-1:0] z_imag;
  logic [PW-1:0]                prod_aa;
  logic [PW-1:0]                prod_bb;
  logic [PW-1:0]                prod_ab;

  logic [WORD_WIDTH-1:0] mag_a;
  logic [WORD_WIDTH-1:0] mag_b;
  logic [MW-1:0]         op_a;
  logic [MW-1:0]         op_b;
  logic [SW-1:0]         aa;
  logic [SW-1:0]         bb;
  logic [SW-1:0]         q;
  logic [SW-1:0]         sum;
  logic                  rem;
  logic                  neg;
  logic signed [SW-1:0]  ab;
  logic signed [SW-1:0]  new_re;
  logic signed [SW-1:0]  new_im;

  function automatic logic signed [WORD_WIDTH-1:0] sat_w(input logic signed [SW-1:0] v);
    logic signed [WORD_WIDTH-1:0] r;
    if (v > WMAX) begin
      r = WMAX[WORD_WIDTH-1:0];
    end else if (v < WMIN) begin
      r = WMIN[WORD_WIDTH-1:0];
    end else begin
      r = v[WORD_WIDTH-1:0];
    end
    return r;
  endfunction

  // magnitudes and multiplier operands
  always_comb begin
    mag_a = z_real[WORD_WIDTH-1] ? (~$unsigned(z_real) + 1'b1) : $unsigned(z_real);
    mag_b = z_imag[WORD_WIDTH-1] ? (~$unsigned(z_imag) + 1'b1) : $unsigned(z_imag);
    op_a  = mag_a[MW-1:0];
    op_b  = mag_b[MW-1:0];
  end

  // round arithmetic on the registered products
  always_comb begin
    aa     = SW'(prod_aa) >> FRAC_BITS;
    bb     = SW'(prod_bb) >> FRAC_BITS;
    q      = SW'(prod_ab) >> FRAC_BITS;
    rem    = |(SW'(prod_ab) & FRAC_MSK);
    sum    = aa + bb;
    neg    = z_real[WORD_WIDTH-1] ^ z_imag[WORD_WIDTH-1];
    ab     = neg ? -($signed(q) + $signed(SW'(rem))) : $signed(q);
    new_re = $signed(aa) - $signed(bb) - SW'(c_real);
    new_im = (ab <<< 1) - SW'(c_imag);
  end

  always_comb begin
    flags.mag_esc = (SW'(mag_a) >= TWO_FIX) || (SW'(mag_b) >= TWO_FIX);
    flags.sum_esc = sum >= FOUR_FIX;
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_aa <= PW'(op_a) * PW'(op_a);
      prod_bb <= PW'(op_b) * PW'(op_b);
      prod_ab <= PW'(op_a) * PW'(op_b);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_z) begin
      z_real <= sat_w(SW'(start_real));
      z_imag <= sat_w(SW'(start_imag));
    end else if (ctrl.upd_z) begin
      z_real <= sat_w(new_re);
      z_imag <= sat_w(new_im);
    end
  end

endmodule

`default_nettype wire

### rtl/core/julia_set_escape_test.sv
// julia_set_escape_test: top level with config registers and microcoded sequencer
// depends on jse_pkg and jse_datapath
`default_nettype none

// A start point is taken at a clock edge where start is high and busy is low.
// The block iterates z = z*z - c on it in fixed point and, when done, pulses done
// for one cycle with inside_res valid; the receiver cannot stall, so the result
// must be taken in that cycle. Each round passes through the sequencer steps MUL,
// which tests the magnitudes and squares through the three registered multipliers,
// and EVAL, which tests the sum and updates z; an escaping point ends early. No new
// point is taken until done. Registers c_real, c_imag and iteration_limit are written
// through wr_en, wr_index and wr_data; writes to other indexes are dropped. They must
// be written only while the block is idle; the block itself does not enforce this.
module julia_set_escape_test #(
  parameter int FRAC_BITS  = jse_pkg::DEFAULT_FRAC_BITS,
  parameter int WORD_WIDTH = jse_pkg::DEFAULT_WORD_WIDTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [jse_pkg::IN_W-1:0]    start_real,
  input  wire logic signed [jse_pkg::IN_W-1:0]    start_imag,
  output logic                                    done,
  output logic                                    inside_res,
  input  wire logic                               wr_en,
  input  wire logic [jse_pkg::INDEX_W-1:0]        wr_index,
  input  wire logic [jse_pkg::IN_W-1:0]           wr_data
);

  logic signed [jse_pkg::IN_W-1:0] c_real;
  logic signed [jse_pkg::IN_W-1:0] c_imag;
  logic [jse_pkg::CNT_W-1:0]       iteration_limit;
  logic [jse_pkg::CNT_W-1:0]       round_count;

  jse_pkg::jse_step_t  step;
  jse_pkg::jse_step_t  step_next;
  jse_pkg::jse_uword_t uw;
  jse_pkg::jse_ctrl_t  ctrl;
  jse_pkg::jse_flags_t flags;

  logic finish_out;
  logic finish_in;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      c_real          <= jse_pkg::C_REAL_RESET;
      c_imag          <= jse_pkg::C_IMAG_RESET;
      iteration_limit <= jse_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        jse_pkg::REG_C_REAL: c_real <= $signed(wr_data);
        jse_pkg::REG_C_IMAG: c_imag <= $signed(wr_data);
        jse_pkg::REG_LIMIT:  iteration_limit <= wr_data[jse_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control word fetch and decode
  always_comb begin
    uw         = jse_pkg::jse_ucode(step);
    finish_out = (uw.chk_mag && flags.mag_esc) || (uw.chk_sum && flags.sum_esc);
    finish_in  = uw.chk_last && !finish_out && (round_count == iteration_limit);
    ctrl.load_z = uw.load_z && start;
    ctrl.mul_en = uw.mul_en;
    ctrl.upd_z  = uw.upd_z && !finish_out && !finish_in;
    busy        = (step != jse_pkg::STEP_IDLE);
  end

  // step counter with conditional jumps
  always_comb begin
    priority if (finish_out || finish_in) begin
      step_next = jse_pkg::STEP_IDLE;
    end else if (!uw.wait_start || start) begin
      step_next = uw.next;
    end else begin
      step_next = step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= jse_pkg::STEP_IDLE;
      done <= 1'b0;
    end else begin
      step <= step_next;
      done <= finish_out || finish_in;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_out || finish_in) begin
      inside_res <= finish_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_count <= '0;
    end else if (ctrl.load_z) begin
      round_count <= '0;
    end else if (ctrl.upd_z) begin
      round_count <= round_count + 1'b1;
    end
  end

  jse_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .ctrl       (ctrl),
    .start_real (start_real),
    .start_imag (start_imag),
    .c_real     (c_real),
    .c_imag     (c_imag),
    .flags      (flags)
  );

endmodule

`default_nettype wire
